FILE: design/mil_pkg.sv
// ----------------------------------------------------------------------------
// mil_pkg
// Shared constants and AES-128 helper functions for the MILENAGE unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mil_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 64;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_OPC_HIGH = 2'd2;
  localparam logic [1:0] REG_OPC_LOW  = 2'd3;

  localparam logic OP_F1  = 1'b0;
  localparam logic OP_F25 = 1'b1;

  typedef logic [127:0] block_t;

  localparam logic [7:0] RCON [NUM_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte n of a block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input block_t b, input int n);
    return b[127 - 8*n -: 8];
  endfunction

endpackage
`default_nettype wire

FILE: design/mil_req_if.sv
// ----------------------------------------------------------------------------
// mil_req_if
// Request channel: opcode, RAND, SQN and AMF with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface mil_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] rand_high;
  logic [63:0] rand_low;
  logic [47:0] seq_number;
  logic [15:0] auth_field;

  modport source (output valid, opcode, rand_high, rand_low, seq_number, auth_field,
                  input ready);
  modport sink   (input valid, opcode, rand_high, rand_low, seq_number, auth_field,
                  output ready);
endinterface
`default_nettype wire

FILE: design/mil_rsp_if.sv
// ----------------------------------------------------------------------------
// mil_rsp_if
// Result channel: MAC-A, MAC-S, RES and AK with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface mil_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] mac_network;
  logic [63:0] mac_resync;
  logic [63:0] response;
  logic [47:0] anonymity_key;

  modport source (output valid, mac_network, mac_resync, response, anonymity_key,
                  input ready);
  modport sink   (input valid, mac_network, mac_resync, response, anonymity_key,
                  output ready);
endinterface
`default_nettype wire

FILE: design/mil_aes_round.sv
// ----------------------------------------------------------------------------
// mil_aes_round
// One AES-128 encryption round with its key expansion step (combinational).
// ----------------------------------------------------------------------------
`default_nettype none
module mil_aes_round (
  input  wire mil_pkg::block_t state_in,
  input  wire mil_pkg::block_t key_in,
  input  wire logic [7:0]      rcon,
  input  wire logic            last,
  output mil_pkg::block_t      state_out,
  output mil_pkg::block_t      key_out
);
  import mil_pkg::*;

  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] k [16];
  logic [7:0] nk [16];
  logic [7:0] rot [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = sbox(get_byte(state_in, i + 4*((c + i) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] all;
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      k[i] = get_byte(key_in, i);
    end
    rot[0] = sbox(k[13]) ^ rcon;
    rot[1] = sbox(k[14]);
    rot[2] = sbox(k[15]);
    rot[3] = sbox(k[12]);
    for (int i = 0; i < 4; i++) begin
      nk[i] = k[i] ^ rot[i];
    end
    for (int i = 4; i < 16; i++) begin
      nk[i] = k[i] ^ nk[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      key_out[127 - 8*i -: 8]   = nk[i];
      state_out[127 - 8*i -: 8] = (last ? t[i] : m[i]) ^ nk[i];
    end
  end
endmodule
`default_nettype wire

FILE: design/milenage_auth_functions_unit.sv
// ----------------------------------------------------------------------------
// milenage_auth_functions_unit
// MILENAGE f1 and f2/f5 over a pipelined pair of AES-128 encryptions.
// ----------------------------------------------------------------------------
// Usage: program K and OPc over the APB port (64-bit registers at byte
// addresses 0, 8, 16, 24: key_high, key_low, opc_high, opc_low) while no
// request is in flight. Requests enter on req, one beat per request; each
// beat yields exactly one result beat on rsp.
// Pipeline: the edge that accepts a request beat loads the entry stage; then
// come ten round stages for TEMP, one mixing stage, ten round stages for
// OUTx and the output register, which raises rsp.valid. Every AES round is
// its own register stage and the round keys travel down the pipe with the
// data.
// Throughput: one request per cycle, except while rsp is stalled with a result waiting.
// Reset clears all stage valid bits and the registers (K and OPc to zero).
// When rsp is stalled with a result waiting, the whole pipe holds and
// req.ready drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
module milenage_auth_functions_unit (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [mil_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mil_pkg::DATA_W-1:0] pwdata,
  output logic [mil_pkg::DATA_W-1:0]      prdata,
  output logic                          pready,
  mil_req_if.sink                       req,
  mil_rsp_if.source                     rsp
);
  import mil_pkg::*;

  logic [63:0] key_high, key_low, opc_high, opc_low;
  block_t      key, opc;

  assign pready = 1'b1;
  assign key = {key_high, key_low};
  assign opc = {opc_high, opc_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      opc_high <= '0;
      opc_low  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        REG_KEY_HIGH: key_high <= pwdata;
        REG_KEY_LOW:  key_low  <= pwdata;
        REG_OPC_HIGH: opc_high <= pwdata;
        REG_OPC_LOW:  opc_low  <= pwdata;
        default:      key_high <= key_high;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_KEY_HIGH: prdata = key_high;
      REG_KEY_LOW:  prdata = key_low;
      REG_OPC_HIGH: prdata = opc_high;
      REG_OPC_LOW:  prdata = opc_low;
      default:      prdata = '0;
    endcase
  end

  logic advance;
  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance;

  // first encryption: TEMP
  logic        v1  [NUM_ROUNDS+1];
  block_t      st1 [NUM_ROUNDS+1];
  block_t      rk1 [NUM_ROUNDS];
  logic        op1 [NUM_ROUNDS+1];
  logic [63:0] hf1 [NUM_ROUNDS+1];
  block_t      st1_next [NUM_ROUNDS+1];
  block_t      rk1_next [NUM_ROUNDS];

  // second encryption: OUT1 / OUT2
  logic        v2  [NUM_ROUNDS+1];
  block_t      st2 [NUM_ROUNDS+1];
  block_t      rk2 [NUM_ROUNDS];
  logic        op2 [NUM_ROUNDS+1];
  block_t      st2_next [NUM_ROUNDS+1];
  block_t      rk2_next [NUM_ROUNDS];

  block_t      x_in;
  block_t      res;

  assign st1_next[0] = {req.rand_high, req.rand_low} ^ opc ^ key;

  always_comb begin
    if (op1[NUM_ROUNDS] == OP_F1) begin
      x_in = {hf1[NUM_ROUNDS] ^ opc_low, hf1[NUM_ROUNDS] ^ opc_high} ^ st1[NUM_ROUNDS];
    end else begin
      x_in = (st1[NUM_ROUNDS] ^ opc) ^ 128'd1;
    end
  end
  assign st2_next[0] = x_in ^ key;

  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    block_t k1, k2;
    mil_aes_round u_r1 (
      .state_in  (st1[r-1]),
      .key_in    (rk1[r-1]),
      .rcon      (RCON[r-1]),
      .last      (r == NUM_ROUNDS),
      .state_out (st1_next[r]),
      .key_out   (k1)
    );
    mil_aes_round u_r2 (
      .state_in  (st2[r-1]),
      .key_in    (rk2[r-1]),
      .rcon      (RCON[r-1]),
      .last      (r == NUM_ROUNDS),
      .state_out (st2_next[r]),
      .key_out   (k2)
    );
    if (r < NUM_ROUNDS) begin : g_key
      assign rk1_next[r] = k1;
      assign rk2_next[r] = k2;
    end
  end
  assign rk1_next[0] = key;
  assign rk2_next[0] = key;

  assign res = st2[NUM_ROUNDS] ^ opc;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NUM_ROUNDS; i++) begin
        v1[i] <= 1'b0;
        v2[i] <= 1'b0;
      end
      rsp.valid <= 1'b0;
    end else if (advance) begin
      v1[0] <= req.valid;
      v2[0] <= v1[NUM_ROUNDS];
      for (int i = 1; i <= NUM_ROUNDS; i++) begin
        v1[i] <= v1[i-1];
        v2[i] <= v2[i-1];
      end
      rsp.valid <= v2[NUM_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i <= NUM_ROUNDS; i++) begin
        st1[i] <= st1_next[i];
        st2[i] <= st2_next[i];
      end
      for (int i = 0; i < NUM_ROUNDS; i++) begin
        rk1[i] <= rk1_next[i];
        rk2[i] <= rk2_next[i];
      end
      op1[0] <= req.opcode;
      hf1[0] <= {req.seq_number, req.auth_field};
      for (int i = 1; i <= NUM_ROUNDS; i++) begin
        op1[i] <= op1[i-1];
        hf1[i] <= hf1[i-1];
        op2[i] <= op2[i-1];
      end
      op2[0] <= op1[NUM_ROUNDS];
      if (op2[NUM_ROUNDS] == OP_F1) begin
        rsp.mac_network   <= res[127:64];
        rsp.mac_resync    <= res[63:0];
        rsp.response      <= '0;
        rsp.anonymity_key <= '0;
      end else begin
        rsp.mac_network   <= '0;
        rsp.mac_resync    <= '0;
        rsp.response      <= res[63:0];
        rsp.anonymity_key <= res[127:80];
      end
    end
  end
endmodule
`default_nettype wire

FILE: sim/tb_milenage_auth_functions_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_milenage_auth_functions_unit
// Drives MILENAGE f1 and f2/f5 requests under several K/OPc settings and
// checks every result beat against an in-bench AES-128 MILENAGE predictor,
// with random idle gaps on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_milenage_auth_functions_unit;
  import mil_pkg::*;

  typedef struct packed {
    logic        opcode;
    logic [63:0] rand_high;
    logic [63:0] rand_low;
    logic [47:0] seq_number;
    logic [15:0] auth_field;
  } challenge_t;

  typedef struct packed {
    logic [63:0] mac_network;
    logic [63:0] mac_resync;
    logic [63:0] response;
    logic [47:0] anonymity_key;
  } auth_vec_t;

  localparam int LATENCY = 23;
  localparam int LIMIT   = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  mil_req_if req ();
  mil_rsp_if rsp ();

  milenage_auth_functions_unit DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [63:0] k_hi, k_lo, opc_hi, opc_lo;
  auth_vec_t expected_vecs[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  function automatic logic [7:0] gmul2(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t aes_encrypt(block_t pt);
    logic [7:0] rk[176];
    logic [7:0] s[16], t[16];
    logic [7:0] w0, w1, w2, w3, tmp, a0, a1, a2, a3, al;
    block_t kb;
    block_t res;
    kb = {k_hi, k_lo};
    for (int i = 0; i < 16; i++) rk[i] = kb[127-8*i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
      if ((i % 16) == 0) begin
        tmp = w0;
        w0 = SBOX[w1] ^ RCON[i/16-1];
        w1 = SBOX[w2]; w2 = SBOX[w3]; w3 = SBOX[tmp];
      end
      rk[i] = rk[i-16] ^ w0; rk[i+1] = rk[i-15] ^ w1;
      rk[i+2] = rk[i-14] ^ w2; rk[i+3] = rk[i-13] ^ w3;
    end
    for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = SBOX[s[i + 4*((c+i) % 4)]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
          s[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
          s[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
          s[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
        end
      end else s = t;
      for (int i = 0; i < 16; i++) s[i] ^= rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  function automatic auth_vec_t milenage_outputs(challenge_t ch);
    block_t opc, temp, x, o;
    logic [63:0] half;
    auth_vec_t v;
    opc = {opc_hi, opc_lo};
    temp = aes_encrypt({ch.rand_high, ch.rand_low} ^ opc);
    v = '0;
    if (ch.opcode == OP_F1) begin
      half = {ch.seq_number, ch.auth_field};
      x = {half ^ opc_lo, half ^ opc_hi} ^ temp;
      o = aes_encrypt(x) ^ opc;
      v.mac_network = o[127:64];
      v.mac_resync = o[63:0];
    end else begin
      x = temp ^ opc ^ 128'd1;
      o = aes_encrypt(x) ^ opc;
      v.response = o[63:0];
      v.anonymity_key = o[127:80];
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 3; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_KEY_HIGH: k_hi = value;
      REG_KEY_LOW:  k_lo = value;
      REG_OPC_HIGH: opc_hi = value;
      REG_OPC_LOW:  opc_lo = value;
    endcase
  endtask

  task automatic load_keys(logic [63:0] a, b, c, d);
    write_reg(REG_KEY_HIGH, a);
    write_reg(REG_KEY_LOW, b);
    write_reg(REG_OPC_HIGH, c);
    write_reg(REG_OPC_LOW, d);
  endtask

  // called at a falling edge; valid stays high after the beat until the
  // next idle gap or drain
  task automatic send_challenge(challenge_t ch);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req.valid <= 1'b1;
    req.opcode <= ch.opcode;
    req.rand_high <= ch.rand_high;
    req.rand_low <= ch.rand_low;
    req.seq_number <= ch.seq_number;
    req.auth_field <= ch.auth_field;
    do @(posedge clk); while (!req.ready);
    expected_vecs.push_back(milenage_outputs(ch));
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic challenge_t rand_challenge();
    challenge_t ch;
    ch.opcode = 1'($urandom_range(1));
    ch.rand_high = rand64();
    ch.rand_low = rand64();
    ch.seq_number = 48'(rand64());
    ch.auth_field = 16'(rand64());
    return ch;
  endfunction

  task automatic drain();
    req.valid <= 1'b0;
    while (expected_vecs.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("milenage_auth_functions_unit test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      rsp.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    auth_vec_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_vecs.size() == 0) begin
        report_mismatch("unexpected beat", rsp.mac_network, '0);
      end else begin
        want = expected_vecs.pop_front();
        if (rsp.mac_network !== want.mac_network)
          report_mismatch("mac_network", rsp.mac_network, want.mac_network);
        if (rsp.mac_resync !== want.mac_resync)
          report_mismatch("mac_resync", rsp.mac_resync, want.mac_resync);
        if (rsp.response !== want.response)
          report_mismatch("response", rsp.response, want.response);
        if (rsp.anonymity_key !== want.anonymity_key)
          report_mismatch("anonymity_key", 64'(rsp.anonymity_key),
                          64'(want.anonymity_key));
      end
    end
  end

  task automatic test_directed();
    challenge_t ch;
    for (int op = 0; op < 2; op++) begin
      ch = '0; ch.opcode = 1'(op); send_challenge(ch);
      ch = '1; ch.opcode = 1'(op); send_challenge(ch);
      ch = '0; ch.opcode = 1'(op); ch.rand_high = 64'h0123456789abcdef;
      ch.rand_low = 64'hfedcba9876543210; ch.seq_number = 48'hff9bb4d0b607;
      ch.auth_field = 16'hb9b9; send_challenge(ch);
      ch.seq_number = '1; ch.auth_field = 16'h8000; send_challenge(ch);
      ch.seq_number = 48'h1; ch.auth_field = 16'h0001; send_challenge(ch);
    end
  endtask

  task automatic test_random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_challenge(rand_challenge());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 300;
    repeat (60) send_challenge(rand_challenge());
  endtask

  initial begin
    k_hi = '0; k_lo = '0; opc_hi = '0; opc_lo = '0;
    req.valid = 1'b0; req.opcode = 1'b0; req.rand_high = '0; req.rand_low = '0;
    req.seq_number = '0; req.auth_field = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    drain();
    load_keys('1, '1, '1, '1);
    test_directed();
    drain();
    load_keys(64'h465b5ce8b199b49f, 64'haa5f0a2ee238a6bc,
              64'hcd63cb71954a9f4e, 64'h48a5994e37a02baf);
    test_directed();
    test_random_phase(250, 0, 0);
    drain();
    load_keys({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    test_random_phase(250, 75, 0);
    test_backpressure();
    drain();
    load_keys({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    test_random_phase(250, 0, 75);
    drain();
    load_keys('0, '1, '0, '1);
    test_random_phase(250, 38, 38);
    drain();

    if (errors == 0 && expected_vecs.size() == 0)
      $display("milenage_auth_functions_unit test passed");
    else
      $display("milenage_auth_functions_unit test failed");
    $finish;
  end
endmodule
